FILE: hw/rtl/sssr_pkg.sv
package sssr_pkg;

   localparam int DATA_W          = 64;
   localparam int MAX_SEQ_LEN_DEF = 32;

   typedef struct packed {
      logic [DATA_W-1:0] payload;
      logic              seq_start;
      logic              batch_end;
   } req_type;

   typedef struct packed {
      logic [DATA_W-1:0] out_payload;
      logic              run_last;
      logic              overflowed;
   } rsp_type;

   // Memory port controls from the sequencer to the step store
   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } store_cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PUSH,
      ST_READ,
      ST_EMIT
   } state_type;

endpackage

FILE: hw/rtl/sssr_store.sv
module sssr_store #(
   parameter int MAX_SEQ_LEN = sssr_pkg::MAX_SEQ_LEN_DEF,
   localparam int AW = $clog2(MAX_SEQ_LEN)
) (
   input  logic                          clock,
   input  sssr_pkg::store_cmd_type       cmd,
   input  logic [AW-1:0]                 addr,
   input  logic [sssr_pkg::DATA_W-1:0]   wr_data,
   output logic [sssr_pkg::DATA_W-1:0]   rd_data
);

   logic [sssr_pkg::DATA_W-1:0] mem [MAX_SEQ_LEN];
   logic [sssr_pkg::DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[addr] <= wr_data;
      end
   end

   // Registered read port; data holds until the next read
   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/sssr_ctrl.sv
module sssr_ctrl #(
   parameter int MAX_SEQ_LEN = sssr_pkg::MAX_SEQ_LEN_DEF,
   localparam int AW = $clog2(MAX_SEQ_LEN),
   localparam int CW = $clog2(MAX_SEQ_LEN + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  sssr_pkg::req_type             req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_run_last,
   output logic                          rsp_overflowed,
   output sssr_pkg::store_cmd_type       store_cmd,
   output logic [AW-1:0]                 store_addr,
   output logic [sssr_pkg::DATA_W-1:0]   store_wr_data
);

   sssr_pkg::state_type state_ff, state_in;
   logic [CW-1:0]       fill_ff, fill_in;
   logic                ovf_ff, ovf_in;
   logic                end_phase_ff, end_phase_in;
   logic                batch_end_ff, batch_end_in;
   logic [sssr_pkg::DATA_W-1:0] payload_ff, payload_in;

   // Shared pointer unit: one adder steps the fill count up or down
   logic                count_up;
   logic [CW-1:0]       fill_step;

   assign fill_step = count_up ? fill_ff + CW'(1) : fill_ff - CW'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sssr_pkg::ST_IDLE;
         fill_ff      <= '0;
         ovf_ff       <= 1'b0;
         end_phase_ff <= 1'b0;
         batch_end_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         ovf_ff       <= ovf_in;
         end_phase_ff <= end_phase_in;
         batch_end_ff <= batch_end_in;
      end
   end

   always_ff @(posedge clock) begin
      payload_ff <= payload_in;
   end

   always_comb begin
      state_in       = state_ff;
      fill_in        = fill_ff;
      ovf_in         = ovf_ff;
      end_phase_in   = end_phase_ff;
      batch_end_in   = batch_end_ff;
      payload_in     = payload_ff;
      count_up       = 1'b0;
      store_cmd      = '0;
      store_addr     = fill_ff[AW-1:0];
      req_ready      = 1'b0;
      rsp_valid      = 1'b0;
      rsp_run_last   = 1'b0;

      unique case (state_ff)
         sssr_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               payload_in   = req_data.payload;
               batch_end_in = req_data.batch_end;
               end_phase_in = 1'b0;
               if (req_data.seq_start && (fill_ff != '0)) begin
                  state_in = sssr_pkg::ST_READ;
               end else begin
                  state_in = sssr_pkg::ST_PUSH;
               end
            end
         end

         sssr_pkg::ST_PUSH: begin
            count_up = 1'b1;
            if (fill_ff < CW'(MAX_SEQ_LEN)) begin
               store_cmd.wr_en = 1'b1;
               fill_in         = fill_step;
            end else begin
               ovf_in = 1'b1;
            end
            if (batch_end_ff) begin
               end_phase_in = 1'b1;
               state_in     = sssr_pkg::ST_READ;
            end else begin
               state_in = sssr_pkg::ST_IDLE;
            end
         end

         sssr_pkg::ST_READ: begin
            // pop the top entry
            store_cmd.rd_en = 1'b1;
            store_addr      = fill_step[AW-1:0];
            fill_in         = fill_step;
            state_in        = sssr_pkg::ST_EMIT;
         end

         sssr_pkg::ST_EMIT: begin
            rsp_valid    = 1'b1;
            rsp_run_last = (fill_ff == '0) && (end_phase_ff || !batch_end_ff);
            if (rsp_ready) begin
               if (fill_ff != '0) begin
                  state_in = sssr_pkg::ST_READ;
               end else if (!end_phase_ff) begin
                  state_in = sssr_pkg::ST_PUSH;
               end else begin
                  state_in = sssr_pkg::ST_IDLE;
               end
            end
         end

         default: begin
            state_in = sssr_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_overflowed = ovf_ff;
   assign store_wr_data  = payload_ff;

endmodule

FILE: hw/rtl/segment_sequence_reverser_top.sv
// Flow: a request that flushes raises its first response in the emit state
//   after a store read state; each further response takes another read
//   and emit state. A plain push request passes through the accept and push
//   states; every popped step adds read and emit states plus any response
//   stall. No new request is taken until the sequencer is back in idle.
// Reset: synchronous, active high; clears the fill count and overflow flag.
module segment_sequence_reverser_top #(
   parameter int MAX_SEQ_LEN = sssr_pkg::MAX_SEQ_LEN_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  sssr_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output sssr_pkg::rsp_type rsp_data
);

   localparam int AW = $clog2(MAX_SEQ_LEN);

   // Sequencer to store controls
   sssr_pkg::store_cmd_type        store_cmd;
   logic [AW-1:0]                  store_addr;
   logic [sssr_pkg::DATA_W-1:0]    store_wr_data;
   logic [sssr_pkg::DATA_W-1:0]    store_rd_data;

   // Response side flags from the sequencer
   logic                           rsp_run_last;
   logic                           rsp_overflowed;

   // Sequencer: owns the fill count (stack pointer), the sticky overflow flag
   // and the drain / push / drain ordering of each request.
   sssr_ctrl #(
      .MAX_SEQ_LEN (MAX_SEQ_LEN)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_run_last   (rsp_run_last),
      .rsp_overflowed (rsp_overflowed),
      .store_cmd      (store_cmd),
      .store_addr     (store_addr),
      .store_wr_data  (store_wr_data)
   );

   // Step store: LIFO storage, one write or one read per cycle. The read
   // register doubles as the response payload register and holds while
   // a response is stalled.
   sssr_store #(
      .MAX_SEQ_LEN (MAX_SEQ_LEN)
   ) u_store (
      .clock   (clock),
      .cmd     (store_cmd),
      .addr    (store_addr),
      .wr_data (store_wr_data),
      .rd_data (store_rd_data)
   );

   // Assemble the response
   always_comb begin
      rsp_data.out_payload = store_rd_data;
      rsp_data.run_last    = rsp_run_last;
      rsp_data.overflowed  = rsp_overflowed;
   end

endmodule

FILE: hw/rtl/sssr_checker.sv
module sssr_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input sssr_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input sssr_pkg::rsp_type rsp_data
);

   // Never take a request while a response is pending
   assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request taken while response pending");

   // Stop accepting right after a request
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted on consecutive cycles");

   // A plain push produces no response
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && !req_data.seq_start && !req_data.batch_end)
      |=> !rsp_valid)
      else $error("response from a plain push");

   // More responses follow a non-final one, so hold off requests
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_data.run_last) |=> !req_ready)
      else $error("request accepted before last response");

   // Stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled response changed");

endmodule

bind segment_sequence_reverser_top sssr_checker u_sssr_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

FILE: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

   // Store depth of the block under test; the model below keeps the same depth.
   localparam int STORE_DEPTH  = sssr_pkg::MAX_SEQ_LEN_DEF;
   localparam int RANDOM_ITEMS = 30;
   localparam int HOLD_CYCLES  = 300;
   // Settle time after the last response is due, plus margin.
   localparam int DRAIN_CYCLES = 16;
   // Generous cap on the whole run, well above the slowest legal run.
   localparam int CYCLE_LIMIT  = 200000;
   localparam int REPORT_MAX   = 10;

   // ------------------------------------------------------------------
   // Clock, reset and block I/O. Every input has a known value at time 0.
   // ------------------------------------------------------------------
   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   sssr_pkg::req_type req_data  = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   sssr_pkg::rsp_type rsp_data;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   segment_sequence_reverser_top #(
      .MAX_SEQ_LEN (STORE_DEPTH)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // ------------------------------------------------------------------
   // Reversal model: a LIFO of payload words, a fill count at the block's
   // width and the sticky overflow bit. Each accepted request appends the
   // responses it causes, oldest first, to expected_pops.
   // ------------------------------------------------------------------
   logic [sssr_pkg::DATA_W-1:0] seq_store [STORE_DEPTH];
   logic [5:0]                  seq_fill     = 6'd0;
   logic                        seq_overflow = 1'b0;
   sssr_pkg::rsp_type           expected_pops [$];

   // Pop the whole store, newest first. The final pop carries run_last when
   // it is the last response this request can cause.
   task automatic pop_stored_steps(input logic mark_last);
      sssr_pkg::rsp_type word;
      while (seq_fill != 6'd0) begin
         seq_fill         = seq_fill - 6'd1;
         word.out_payload = seq_store[seq_fill];
         word.overflowed  = seq_overflow;
         word.run_last    = mark_last && (seq_fill == 6'd0);
         expected_pops.push_back(word);
      end
   endtask

   // Order within one request: flush on seq_start, then push, then flush on
   // batch_end. The batch_end flush sees the store non-empty after any push,
   // so the seq_start flush is last only when batch_end is clear.
   task automatic predict_reversal(input sssr_pkg::req_type req);
      if (req.seq_start) begin
         pop_stored_steps(!req.batch_end);
      end
      if (seq_fill < STORE_DEPTH) begin
         seq_store[seq_fill] = req.payload;
         seq_fill            = seq_fill + 6'd1;
      end else begin
         // Full store: drop the step and latch the flag until reset.
         seq_overflow = 1'b1;
      end
      if (req.batch_end) begin
         pop_stored_steps(1'b1);
      end
   endtask

   // ------------------------------------------------------------------
   // Flow control shared by both sides. steady_flow suppresses idling on
   // both channels; hold_armed asks the receiver for a long hold-off.
   // ------------------------------------------------------------------
   logic steady_flow = 1'b0;
   logic hold_armed  = 1'b0;
   logic hold_seen   = 1'b0;
   int   hold_left   = 0;

   // Receiver: count the hold-off here so the sender keeps offering requests
   // while responses back up and the block stalls its input.
   always @(posedge clock) begin
      if (hold_armed && !hold_seen) begin
         hold_seen <= 1'b1;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (steady_flow) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= 28);
      end
   end

   // ------------------------------------------------------------------
   // Response checker: compare every accepted response with the oldest
   // expectation, field by field.
   // ------------------------------------------------------------------
   int                fail_count = 0;
   sssr_pkg::rsp_type want_pop;

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_pops.size() == 0) begin
            fail_count++;
            if (fail_count <= REPORT_MAX) begin
               $display("unexpected response: payload %h run_last %b overflowed %b",
                        rsp_data.out_payload, rsp_data.run_last, rsp_data.overflowed);
            end
         end else begin
            want_pop = expected_pops.pop_front();
            if (rsp_data.out_payload !== want_pop.out_payload ||
                rsp_data.run_last    !== want_pop.run_last    ||
                rsp_data.overflowed  !== want_pop.overflowed) begin
               fail_count++;
               if (fail_count <= REPORT_MAX) begin
                  $display("mismatch: payload exp %h got %h, run_last exp %b got %b, %s",
                           want_pop.out_payload, rsp_data.out_payload,
                           want_pop.run_last, rsp_data.run_last,
                           $sformatf("overflowed exp %b got %b",
                                     want_pop.overflowed, rsp_data.overflowed));
               end
            end
         end
      end
   end

   // Timeout: a hung handshake ends the run here.
   int cycle_count = 0;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Sender. Called at a rising edge; returns at the edge that accepts the
   // request with req_valid still high, so back-to-back requests never
   // drop valid. Idle cycles lower valid before the next request goes out.
   // ------------------------------------------------------------------
   task automatic send_request(input logic [sssr_pkg::DATA_W-1:0] payload,
                               input logic seq_start, input logic batch_end);
      sssr_pkg::req_type req;
      req.payload   = payload;
      req.seq_start = seq_start;
      req.batch_end = batch_end;
      if (!steady_flow) begin
         while ($urandom_range(99) < 28) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_data  <= req;
      req_valid <= 1'b1;
      do begin
         @(posedge clock);
      end while (!req_ready);
      predict_reversal(req);
   endtask

   function automatic logic [sssr_pkg::DATA_W-1:0] random_word();
      return {$urandom, $urandom};
   endfunction

   // Send one sequence of n steps; optionally close the batch on its last step.
   task automatic send_sequence(input int n, input logic close_batch);
      for (int k = 0; k < n; k++) begin
         send_request(random_word(), k == 0, close_batch && (k == n - 1));
      end
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Extremes of the payload and every flag combination on short sequences.
   task automatic test_directed();
      // Start on an empty store: no response, step is pushed.
      send_request('0, 1'b1, 1'b0);
      send_request('1, 1'b0, 1'b0);
      // Start flushes the two stored steps, newest first.
      send_request(64'h0123_4567_89AB_CDEF, 1'b1, 1'b0);
      // Batch end alone: push then flush both.
      send_request(64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 1'b1);
      // Start and end on an empty store: a length-one sequence comes back unchanged.
      send_request(64'h5555_5555_5555_5555, 1'b1, 1'b1);
      // Plain push with no flags: no response.
      send_request('0, 1'b0, 1'b0);
      // Start and end on one stored step: one pop each side of the push.
      send_request('1, 1'b1, 1'b1);
      // Length-one sequence flushed by the next start.
      send_request(64'h8000_0000_0000_0001, 1'b1, 1'b0);
      send_request(64'h7FFF_FFFF_FFFF_FFFE, 1'b1, 1'b0);
      // Three-step sequence, then a batch end that carries its own step.
      send_request(64'hFFFF_FFFF_0000_0000, 1'b0, 1'b0);
      send_request(64'h0000_0000_FFFF_FFFF, 1'b0, 1'b0);
      send_request(random_word(), 1'b0, 1'b1);
      // Two short sequences closing a batch.
      send_sequence(2, 1'b0);
      send_sequence(3, 1'b1);
      send_request('1, 1'b0, 1'b1);
   endtask

   // Mostly well-formed sequences with random payloads, some noise requests
   // with random flags. Never let the store overflow here.
   task automatic test_random_sequences();
      int   sent;
      int   seq_len;
      logic close_batch;
      logic start_flag;
      logic end_flag;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         // Hold both sides busy-free for a stretch in the middle.
         steady_flow = (sent >= 5 && sent < 25);
         if ($urandom_range(99) < 15) begin
            start_flag = 1'($urandom_range(1));
            end_flag   = 1'($urandom_range(1));
            if (seq_fill == STORE_DEPTH) begin
               start_flag = 1'b1;
            end
            send_request(random_word(), start_flag, end_flag);
            sent++;
         end else begin
            if ($urandom_range(9) == 0) begin
               seq_len = $urandom_range(STORE_DEPTH, 16);
            end else begin
               seq_len = $urandom_range(6, 1);
            end
            if (seq_len > RANDOM_ITEMS - sent) begin
               seq_len = RANDOM_ITEMS - sent;
            end
            close_batch = ($urandom_range(3) == 0);
            send_sequence(seq_len, close_batch);
            sent += seq_len;
         end
      end
      steady_flow = 1'b0;
   endtask

   // Receiver holds off while a full store is flushed with the longest
   // response burst; the block must stall its input meanwhile.
   task automatic test_backpressure();
      hold_armed <= 1'b1;
      send_sequence(STORE_DEPTH, 1'b0);
      // Flush of a full store, push, then flush the new step: max burst.
      send_request(random_word(), 1'b1, 1'b1);
      send_sequence(4, 1'b0);
      send_sequence(3, 1'b1);
   endtask

   // Overflow is sticky until reset, so this runs last.
   task automatic test_overflow();
      send_sequence(STORE_DEPTH, 1'b0);
      // Full store: drop a few steps with no flags.
      send_request(random_word(), 1'b0, 1'b0);
      send_request(random_word(), 1'b0, 1'b0);
      // Batch end on a full store: step dropped, flush reports the flag.
      send_request(random_word(), 1'b0, 1'b1);
      // Start flush still reports the latched flag.
      send_sequence(3, 1'b0);
      send_sequence(2, 1'b1);
      send_request(random_word(), 1'b1, 1'b1);
   endtask

   // Drop valid and wait for every expected response, then let the block settle.
   task automatic finish_requests();
      req_valid <= 1'b0;
      while (expected_pops.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random_sequences();
      test_backpressure();
      test_overflow();
      finish_requests();
      if (fail_count == 0 && expected_pops.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

FILE: files.f
hw/rtl/sssr_pkg.sv
hw/rtl/sssr_store.sv
hw/rtl/sssr_ctrl.sv
hw/rtl/segment_sequence_reverser_top.sv
hw/rtl/sssr_checker.sv
tb/tb_top.sv
